/* sv/nos_pkg.sv */
// shared widths, operation codes and chain types for the orientation search
package nos_pkg;

  localparam int MAX_REFS_DEF = 256;

  localparam int FUNC_W  = 2;
  localparam int ALPHA_W = 25;
  localparam int BETA_W  = 24;
  localparam int GAMMA_W = 25;
  localparam int IDX_W   = 8;
  // worst case sum of the three absolute differences
  localparam int DIST_W  = 27;

  localparam int S_DATA_RAW_W = ALPHA_W + BETA_W + GAMMA_W;
  localparam int S_DATA_W     = ((S_DATA_RAW_W + 7) / 8) * 8;
  localparam int M_DATA_W     = IDX_W;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [ALPHA_W-1:0] alpha;
    logic [BETA_W-1:0]  beta;
    logic [GAMMA_W-1:0] gamma;
  } query_t;

  typedef struct packed {
    logic              valid;
    logic              have;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] l1_dist;
  } best_t;

endpackage

/* sv/nos_cell.sv */
// one search cell: holds one reference and folds its distance into the running best
module nos_cell #(
  parameter int MAX_REFS = nos_pkg::MAX_REFS_DEF,
  parameter int INDEX    = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(MAX_REFS+1)-1:0]  count,
  input  logic                           wr_en,
  input  logic [nos_pkg::ALPHA_W-1:0]    wr_alpha,
  input  logic [nos_pkg::BETA_W-1:0]     wr_beta,
  input  logic [nos_pkg::GAMMA_W-1:0]    wr_gamma,
  input  nos_pkg::query_t                q_in,
  output nos_pkg::query_t                q_out,
  input  nos_pkg::best_t                 b_in,
  output nos_pkg::best_t                 b_out
);
  import nos_pkg::*;

  localparam int CNT_W = $clog2(MAX_REFS + 1);

  logic [ALPHA_W-1:0] ref_alpha;
  logic [BETA_W-1:0]  ref_beta;
  logic [GAMMA_W-1:0] ref_gamma;
  logic [DIST_W-1:0]  l1_dist;
  logic [DIST_W-1:0]  l1_dist_next;
  logic               active;
  logic [ALPHA_W-1:0] da;
  logic [BETA_W-1:0]  db;
  logic [GAMMA_W-1:0] dg;
  logic               take;

  always_comb begin
    da = (q_in.alpha >= ref_alpha) ? q_in.alpha - ref_alpha : ref_alpha - q_in.alpha;
    db = (q_in.beta  >= ref_beta)  ? q_in.beta  - ref_beta  : ref_beta  - q_in.beta;
    dg = (q_in.gamma >= ref_gamma) ? q_in.gamma - ref_gamma : ref_gamma - q_in.gamma;
    l1_dist_next = DIST_W'(da) + DIST_W'(db) + DIST_W'(dg);
  end

  // strict less keeps the lower index on a tie
  assign take = active && (!b_in.have || (l1_dist < b_in.l1_dist));

  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_W'(INDEX))) begin
      ref_alpha <= wr_alpha;
      ref_beta  <= wr_beta;
      ref_gamma <= wr_gamma;
    end
    q_out.alpha <= q_in.alpha;
    q_out.beta  <= q_in.beta;
    q_out.gamma <= q_in.gamma;
    l1_dist     <= l1_dist_next;
    active      <= (CNT_W'(INDEX) < count);
    if (take) begin
      b_out.have    <= 1'b1;
      b_out.idx     <= IDX_W'(INDEX);
      b_out.l1_dist <= l1_dist;
    end else begin
      b_out.have    <= b_in.have;
      b_out.idx     <= b_in.idx;
      b_out.l1_dist <= b_in.l1_dist;
    end
    if (rst) begin
      q_out.valid <= 1'b0;
      b_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_in.valid;
      b_out.valid <= q_out.valid;
    end
  end

endmodule

/* sv/nearest_orientation_search_core.sv */
// top level of the nearest orientation search: stream ports, entry count, cell row
// A row of MAX_REFS cells, each holding one reference orientation (alpha, beta,
// gamma). Clear and append produce no result transfer; an append to a full
// table is dropped. A query is injected at the head of the row and walks one
// cell per cycle; each cell registers its L1 distance and folds it into the
// running best in the next cycle, so the best trails the query down the row.
// The result transfer appears once the best has left the last cell and been
// registered at the output, and the block holds off all input until then. A
// result waiting at the output does not hold off clear or append; a further
// query waits only if the output register is still occupied. On a tie the
// lowest index wins; with an empty table found is 0 and the index is 0. The
// index carries its low 8 bits.
module nearest_orientation_search_core #(
  parameter int MAX_REFS = nos_pkg::MAX_REFS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // alpha [24:0], beta [48:25], gamma [73:49], zero pad above
  input  logic [nos_pkg::S_DATA_W-1:0]  s_tdata,
  // func [1:0]
  input  logic [nos_pkg::FUNC_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // nearest_index [7:0]
  output logic [nos_pkg::M_DATA_W-1:0]  m_tdata,
  // found [0]
  output logic [0:0]                    m_tuser
);
  import nos_pkg::*;

  localparam int CNT_W = $clog2(MAX_REFS + 1);

  // unpacked input fields
  logic [ALPHA_W-1:0] in_alpha;
  logic [BETA_W-1:0]  in_beta;
  logic [GAMMA_W-1:0] in_gamma;
  logic               in_acc;
  logic               is_append;
  logic               is_query;

  // control state
  logic [CNT_W-1:0]   count;
  logic               busy;
  logic               out_valid;
  logic [IDX_W-1:0]   out_idx;
  logic               out_found;

  // the cell row
  query_t q_chain [0:MAX_REFS];
  best_t  b_chain [0:MAX_REFS];
  best_t  res;

  assign in_alpha = s_tdata[ALPHA_W-1:0];
  assign in_beta  = s_tdata[ALPHA_W+BETA_W-1:ALPHA_W];
  assign in_gamma = s_tdata[ALPHA_W+BETA_W+GAMMA_W-1:ALPHA_W+BETA_W];

  // a query needs the output register free by the time its result lands
  assign s_tready  = !busy && ((s_tuser != FUNC_QUERY) || !out_valid || m_tready);
  assign in_acc    = s_tvalid && s_tready;
  assign is_append = in_acc && (s_tuser == FUNC_APPEND) && (count != CNT_W'(MAX_REFS));
  assign is_query  = in_acc && (s_tuser == FUNC_QUERY);

  // head of the row: fresh query, empty best
  assign q_chain[0].valid = is_query;
  assign q_chain[0].alpha = in_alpha;
  assign q_chain[0].beta  = in_beta;
  assign q_chain[0].gamma = in_gamma;
  assign b_chain[0]       = '0;

  for (genvar i = 0; i < MAX_REFS; i++) begin : g_cell
    nos_cell #(
      .MAX_REFS (MAX_REFS),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .wr_en    (is_append),
      .wr_alpha (in_alpha),
      .wr_beta  (in_beta),
      .wr_gamma (in_gamma),
      .q_in     (q_chain[i]),
      .q_out    (q_chain[i+1]),
      .b_in     (b_chain[i]),
      .b_out    (b_chain[i+1])
    );
  end

  assign res = b_chain[MAX_REFS];

  // entry count; clear only rewinds it, stale references stay but are never active
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      case (s_tuser)
        FUNC_CLEAR:  count <= '0;
        FUNC_APPEND: begin
          if (count != CNT_W'(MAX_REFS)) begin
            count <= count + CNT_W'(1);
          end
        end
        default:     count <= count;
      endcase
    end
  end

  // query in flight and output register
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_idx   <= res.have ? res.idx : '0;
      out_found <= res.have;
    end
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (is_query) begin
        busy <= 1'b1;
      end else if (res.valid) begin
        busy <= 1'b0;
      end
      if (res.valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_idx;
  assign m_tuser[0] = out_found;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REFS))
    else $error("entry count beyond table size");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> busy)
    else $error("row result without a query in flight");

  a_output_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || m_tready))
    else $error("row result would overwrite a pending transfer");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("index not zero when nothing found");

endmodule

/* bench/tb_nearest_orientation_search_core.sv */
// self-checking bench for the nearest orientation search core: table, scoreboard and stimulus
module tb_nearest_orientation_search_core;
  import nos_pkg::*;

  localparam int REFS = MAX_REFS_DEF;
  localparam int unsigned ALPHA_HI = 23592960;
  localparam int unsigned BETA_HI  = 11796480;
  localparam int unsigned GAMMA_HI = 23592960;
  // code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEMS = 1400;
  // every item a query, each held up by both sides, and plenty of margin on top
  localparam int LIMIT = 2000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [0:0]          m_tuser;

  int  cycles = 0;
  int  useful = 0;
  // a stretch of the run with neither side idling
  wire steady = (cycles >= 20000) && (cycles < 50000);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             found;
  } nearest_t;

  // keeps its own reference table and the queue of nearest matches still owed
  class nearest_checker;
    logic [ALPHA_W-1:0] alpha_tab [REFS];
    logic [BETA_W-1:0]  beta_tab  [REFS];
    logic [GAMMA_W-1:0] gamma_tab [REFS];
    int                 entries;
    nearest_t           pending [$];
    int                 errors;
    int                 seen;

    function new();
      entries = 0;
      errors  = 0;
      seen    = 0;
    endfunction

    function longint unsigned span(logic [31:0] x, logic [31:0] y);
      return (x >= y) ? {32'd0, x - y} : {32'd0, y - x};
    endfunction

    // least l1 distance over the live entries, lowest index on a tie
    function nearest_t nearest_to(logic [ALPHA_W-1:0] a, logic [BETA_W-1:0] b,
                                  logic [GAMMA_W-1:0] g);
      nearest_t        res;
      longint unsigned d;
      longint unsigned best_d;
      res.idx   = '0;
      res.found = 1'b0;
      best_d    = 0;
      for (int i = 0; i < entries; i++) begin
        d = span({7'd0, alpha_tab[i]}, {7'd0, a}) + span({8'd0, beta_tab[i]}, {8'd0, b})
          + span({7'd0, gamma_tab[i]}, {7'd0, g});
        if (!res.found || d < best_d) begin
          res.found = 1'b1;
          best_d    = d;
          res.idx   = i[IDX_W-1:0];
        end
      end
      return res;
    endfunction

    // returns 0 for transfers the block just drops
    function bit note_request(logic [FUNC_W-1:0] f, logic [ALPHA_W-1:0] a,
                              logic [BETA_W-1:0] b, logic [GAMMA_W-1:0] g);
      case (f)
        FUNC_CLEAR: begin
          entries = 0;
          return 1'b1;
        end
        FUNC_APPEND: begin
          if (entries >= REFS) return 1'b0;
          alpha_tab[entries] = a;
          beta_tab[entries]  = b;
          gamma_tab[entries] = g;
          entries++;
          return 1'b1;
        end
        FUNC_QUERY: begin
          pending.push_back(nearest_to(a, b, g));
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic found);
      nearest_t want;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with no query outstanding: index %0d found %0b",
                         seen, idx, found));
        return;
      end
      want = pending.pop_front();
      if (want.idx !== idx || want.found !== found)
        report($sformatf("result %0d: expected index %0d found %0b, got index %0d found %0b",
                         seen, want.idx, want.found, idx, found));
    endfunction
  endclass

  nearest_checker sb = new();

  nearest_orientation_search_core #(
    .MAX_REFS(REFS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // watchdog
  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("tb_nearest_orientation_search_core: errors");
    $finish;
  end

  // receiver: back-pressure about one cycle in ten, none in the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 10);
  end

  // result transfers, values as they stood just before the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[IDX_W-1:0], m_tuser[0]);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ALPHA_W-1:0] a,
                           input logic [BETA_W-1:0] b, input logic [GAMMA_W-1:0] g);
    logic [S_DATA_W-1:0] word;
    word = '0;
    word[0 +: ALPHA_W] = a;
    word[ALPHA_W +: BETA_W] = b;
    word[ALPHA_W + BETA_W +: GAMMA_W] = g;
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.note_request(f, a, b, g)) useful++;
  endtask

  // hold the sender off until every owed result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // in-range mostly, sometimes the full field width; grid mode makes ties common
  function automatic logic [31:0] pick_angle(int w, int unsigned hi, bit grid);
    int unsigned r;
    logic [31:0] mask;
    mask = (32'd1 << w) - 32'd1;
    r = $urandom_range(99);
    if (grid) return $urandom_range(3) * (hi / 4);
    if (r < 60) return $urandom_range(hi);
    if (r < 80) return $urandom & mask;
    if (r < 87) return 32'd0;
    if (r < 94) return hi;
    return mask;
  endfunction

  task automatic send_noise(input logic [FUNC_W-1:0] f);
    logic [31:0] ra, rb, rg;
    ra = $urandom;
    rb = $urandom;
    rg = $urandom;
    send_item(f, ra[ALPHA_W-1:0], rb[BETA_W-1:0], rg[GAMMA_W-1:0]);
  endtask

  task automatic send_append(input bit grid);
    int unsigned k;
    logic [31:0] ra, rb, rg;
    if (sb.entries != 0 && $urandom_range(3) == 0) begin
      // duplicate of a stored entry, so the lowest index has to win
      k  = $urandom_range(sb.entries - 1);
      ra = {7'd0, sb.alpha_tab[k]};
      rb = {8'd0, sb.beta_tab[k]};
      rg = {7'd0, sb.gamma_tab[k]};
    end else begin
      ra = pick_angle(ALPHA_W, ALPHA_HI, grid);
      rb = pick_angle(BETA_W, BETA_HI, grid);
      rg = pick_angle(GAMMA_W, GAMMA_HI, grid);
    end
    send_item(FUNC_APPEND, ra[ALPHA_W-1:0], rb[BETA_W-1:0], rg[GAMMA_W-1:0]);
  endtask

  task automatic send_query(input bit grid);
    int unsigned k;
    logic [31:0] ra, rb, rg;
    if (sb.entries != 0 && $urandom_range(1) == 0) begin
      // close to a stored entry, sometimes right on it
      k  = $urandom_range(sb.entries - 1);
      ra = {7'd0, sb.alpha_tab[k]};
      rb = {8'd0, sb.beta_tab[k]};
      rg = {7'd0, sb.gamma_tab[k]};
      if ($urandom_range(2) != 0) begin
        ra = ra + $urandom_range(64) - 32'd32;
        rb = rb + $urandom_range(64) - 32'd32;
        rg = rg + $urandom_range(64) - 32'd32;
      end
    end else begin
      ra = pick_angle(ALPHA_W, ALPHA_HI, grid);
      rb = pick_angle(BETA_W, BETA_HI, grid);
      rg = pick_angle(GAMMA_W, GAMMA_HI, grid);
    end
    send_item(FUNC_QUERY, ra[ALPHA_W-1:0], rb[BETA_W-1:0], rg[GAMMA_W-1:0]);
  endtask

  initial begin
    int  phase;
    int  n_app;
    int  n_q;
    bit  grid;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, field extremes, ties, unused code, clear
    send_item(FUNC_QUERY, '0, '0, '0);
    send_item(FUNC_APPEND, '0, '0, '0);
    send_item(FUNC_APPEND, '1, '1, '1);
    send_item(FUNC_APPEND, ALPHA_HI[ALPHA_W-1:0], BETA_HI[BETA_W-1:0], GAMMA_HI[GAMMA_W-1:0]);
    send_item(FUNC_APPEND, '0, '0, '0);
    send_item(FUNC_APPEND, 25'd6553600, '0, '0);
    send_item(FUNC_APPEND, 25'd19660800, '0, '0);
    send_item(FUNC_QUERY, '0, '0, '0);
    send_item(FUNC_QUERY, '1, '1, '1);
    send_item(FUNC_QUERY, ALPHA_HI[ALPHA_W-1:0], BETA_HI[BETA_W-1:0], GAMMA_HI[GAMMA_W-1:0]);
    // equidistant from the 100 and 300 degree entries
    send_item(FUNC_QUERY, 25'd13107200, '0, '0);
    send_item(FUNC_UNUSED, '1, '1, '1);
    send_item(FUNC_QUERY, 25'h0AAAAAA, 24'h555555, 25'h1555555);
    send_item(FUNC_CLEAR, '1, '1, '1);
    send_item(FUNC_QUERY, '0, '0, '0);
    send_item(FUNC_APPEND, 25'h1555555, 24'hAAAAAA, 25'h0AAAAAA);
    send_item(FUNC_QUERY, '0, '0, '0);
    drain_results();

    // random: build a table, probe it, now and then wipe it
    phase = 0;
    while (useful < ITEMS) begin
      grid = ($urandom_range(3) == 0);
      if (phase == 4 || phase == 40) begin
        // fill to the brim, then push a few appends past it
        send_noise(FUNC_CLEAR);
        repeat (REFS + 4) send_append(1'b0);
        repeat (4) send_query(1'b0);
      end else begin
        if ($urandom_range(1) == 0) send_noise(FUNC_CLEAR);
        n_app = $urandom_range(12);
        n_q   = $urandom_range(4, 1);
        repeat (n_app) send_append(grid);
        repeat (n_q) send_query(grid);
        if ($urandom_range(9) == 0) send_noise(FUNC_UNUSED);
      end
      if (phase == 2 || $urandom_range(9) == 0) drain_results();
      phase++;
    end

    drain_results();
    repeat (REFS + 16) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_nearest_orientation_search_core: clean");
    end else begin
      $display("tb_nearest_orientation_search_core: errors");
    end
    $finish;
  end

endmodule
